// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the matrix multiply unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MMU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mmu assertion failed");

// Next-cycle implication, checked out of reset.
`define MMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mmu assertion failed");

`endif

// ----- rtl/mmu_pkg.sv -----
// Shared types, codes and default sizes of the matrix multiply unit.
`timescale 1ns / 1ps
`default_nettype none
package mmu_pkg;

    localparam int unsigned MAX_DIM_DEF    = 8;
    localparam int unsigned ELEM_WIDTH_DEF = 16;

    localparam int unsigned POS_W  = 3;   // row / column port width
    localparam int unsigned SUM_W  = 35;  // Q19.16 sum width
    localparam int unsigned FUNC_W = 2;
    localparam int unsigned CFG_W  = 4;

    // Input item operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    // One multiply-accumulate step issued by the sequencer
    typedef struct packed {
        logic             valid;
        logic             first;   // first term of a dot product
        logic             last_k;  // final term, result leaves
        logic             err;     // dimension mismatch result
        logic             last;    // final result of the run
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_step;

    // One finished product element
    typedef struct packed {
        logic                    valid;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [SUM_W-1:0] value;
        logic                    last;
        logic                    err;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/matrix_multiply_unit.sv -----
// Matrix multiply unit top level: configuration port, element stores, sequencer, output beat.
// Loads never produce a beat; the input is ready at once again.
// A compute item holds the input for all M*N*K steps (a single step on a dimension mismatch),
// the sequencer issuing one multiply-accumulate step per cycle while the result side does not stall.
// A step's result passes the read and step registers, the product register and the output beat.
// Synchronous active-low reset sets every dimension register to 8 and idles the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_unit
    import mmu_pkg::*;
#(
    parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
    parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    // input item channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [FUNC_W-1:0]       i_func,
    input  wire logic [POS_W-1:0]        i_elem_row,
    input  wire logic [POS_W-1:0]        i_elem_col,
    input  wire logic signed [15:0]      i_elem_value,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic      [POS_W-1:0]        o_out_row,
    output logic      [POS_W-1:0]        o_out_col,
    output logic signed [SUM_W-1:0]      o_product_value,
    output logic                         o_last,
    output logic                         o_dim_error
);

    localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
    localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned IX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Clamp a dimension register and return its last index
    function automatic logic [IX_W-1:0] f_last_idx(input logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] d;
        begin
            if (r == '0) begin
                d = '0;
            end else if (r > CFG_W'(MAX_DIM)) begin
                d = CFG_W'(MAX_DIM - 1);
            end else begin
                d = r - 1'b1;
            end
            return d[IX_W-1:0];
        end
    endfunction

    logic [CFG_W-1:0]      r_a_rows;
    logic [CFG_W-1:0]      r_a_cols;
    logic [CFG_W-1:0]      r_b_rows;
    logic [CFG_W-1:0]      r_b_cols;

    logic                  r_state;
    logic                  r_err;
    logic [IX_W-1:0]       r_i;
    logic [IX_W-1:0]       r_j;
    logic [IX_W-1:0]       r_k;
    logic [IX_W-1:0]       r_m_last;
    logic [IX_W-1:0]       r_n_last;
    logic [IX_W-1:0]       r_k_last;

    logic                  w_cfg_wr;
    logic                  w_in_acc;
    logic                  w_adv;
    logic                  w_in_range;
    logic                  w_we_a;
    logic                  w_we_b;
    logic [IDX_W-1:0]      w_waddr;
    logic [IDX_W-1:0]      w_a_raddr;
    logic [IDX_W-1:0]      w_b_raddr;
    logic [ELEM_WIDTH-1:0] w_elem;
    logic [ELEM_WIDTH-1:0] w_a_data;
    logic [ELEM_WIDTH-1:0] w_b_data;
    logic                  w_k_end;
    logic                  w_j_end;
    logic                  w_i_end;
    t_step                 w_step;
    t_step                 r_step;
    t_result               w_res;

    logic                  r_out_valid;
    logic [POS_W-1:0]      r_out_row;
    logic [POS_W-1:0]      r_out_col;
    logic signed [SUM_W-1:0] r_out_value;
    logic                  r_out_last;
    logic                  r_out_err;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= CFG_W'(8);
            r_a_cols <= CFG_W'(8);
            r_b_rows <= CFG_W'(8);
            r_b_cols <= CFG_W'(8);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_A_ROWS: r_a_rows <= pwdata[CFG_W-1:0];
                REG_A_COLS: r_a_cols <= pwdata[CFG_W-1:0];
                REG_B_ROWS: r_b_rows <= pwdata[CFG_W-1:0];
                REG_B_COLS: r_b_cols <= pwdata[CFG_W-1:0];
                default:    r_a_rows <= r_a_rows;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_A_ROWS: prdata = {28'd0, r_a_rows};
            REG_A_COLS: prdata = {28'd0, r_a_cols};
            REG_B_ROWS: prdata = {28'd0, r_b_rows};
            REG_B_COLS: prdata = {28'd0, r_b_cols};
            default:    prdata = '0;
        endcase
    end

    // Pipeline moves whenever the output beat is free or leaving
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Element load: drop writes outside the store
    assign w_in_range = ({1'b0, i_elem_row} < (POS_W + 1)'(MAX_DIM)) &&
                        ({1'b0, i_elem_col} < (POS_W + 1)'(MAX_DIM));
    assign w_we_a  = w_in_acc && (i_func == FUNC_WRITE_A) && w_in_range;
    assign w_we_b  = w_in_acc && (i_func == FUNC_WRITE_B) && w_in_range;
    assign w_waddr = IDX_W'(32'(i_elem_row) * MAX_DIM + 32'(i_elem_col));

    generate
        if (ELEM_WIDTH <= 16) begin : g_elem_narrow
            assign w_elem = i_elem_value[ELEM_WIDTH-1:0];
        end else begin : g_elem_wide
            assign w_elem = {{(ELEM_WIDTH - 16){1'b0}}, i_elem_value};
        end
    endgenerate

    // Sequencer: walk i, j, k in row-major order, one step per cycle while the pipeline advances
    assign w_k_end = (r_k == r_k_last);
    assign w_j_end = (r_j == r_n_last);
    assign w_i_end = (r_i == r_m_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_err   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_func == FUNC_COMPUTE)) begin
                        r_state <= ST_RUN;
                        r_err   <= (f_last_idx(r_a_cols) != f_last_idx(r_b_rows));
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                    end
                end
                ST_RUN: begin
                    if (w_adv) begin
                        if (r_err) begin
                            r_state <= ST_IDLE;
                        end else if (!w_k_end) begin
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_k <= '0;
                            if (!w_j_end) begin
                                r_j <= r_j + 1'b1;
                            end else begin
                                r_j <= '0;
                                if (!w_i_end) begin
                                    r_i <= r_i + 1'b1;
                                end else begin
                                    r_state <= ST_IDLE;
                                end
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Capture clamped dimensions at the start of a run
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_func == FUNC_COMPUTE)) begin
            r_m_last <= f_last_idx(r_a_rows);
            r_k_last <= f_last_idx(r_a_cols);
            r_n_last <= f_last_idx(r_b_cols);
        end
    end

    // Issue the current step and its read addresses
    always_comb begin
        w_step.valid  = (r_state == ST_RUN);
        w_step.first  = (r_k == '0);
        w_step.last_k = r_err || w_k_end;
        w_step.err    = r_err;
        w_step.last   = r_err || (w_i_end && w_j_end && w_k_end);
        w_step.row    = r_err ? '0 : POS_W'(r_i);
        w_step.col    = r_err ? '0 : POS_W'(r_j);
    end

    assign w_a_raddr = IDX_W'(32'(r_i) * MAX_DIM + 32'(r_k));
    assign w_b_raddr = IDX_W'(32'(r_k) * MAX_DIM + 32'(r_j));

    mmu_store #(
        .DEPTH  (DEPTH),
        .WIDTH  (ELEM_WIDTH),
        .ADDR_W (IDX_W)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_re    (w_adv),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_data)
    );

    mmu_store #(
        .DEPTH  (DEPTH),
        .WIDTH  (ELEM_WIDTH),
        .ADDR_W (IDX_W)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_re    (w_adv),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_data)
    );

    // Align the step with the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (w_adv) begin
            r_step <= w_step;
        end
    end

    mmu_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_step  (r_step),
        .i_a     (w_a_data),
        .i_b     (w_b_data),
        .o_res   (w_res)
    );

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_out_row   <= w_res.row;
            r_out_col   <= w_res.col;
            r_out_value <= w_res.value;
            r_out_last  <= w_res.last;
            r_out_err   <= w_res.err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;
    assign o_dim_error     = r_out_err;

endmodule
`default_nettype wire

// ----- rtl/mmu_store.sv -----
// Single-port-write, single-port-read element memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mmu_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 16,
    parameter int unsigned ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one element
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one element, hold while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/mmu_mac.sv -----
// Shared multiply-accumulate unit: one signed product and one 35-bit add per step.
`timescale 1ns / 1ps
`default_nettype none
module mmu_mac
    import mmu_pkg::*;
#(
    parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire t_step                 i_step,
    input  wire logic [ELEM_WIDTH-1:0] i_a,
    input  wire logic [ELEM_WIDTH-1:0] i_b,
    output t_result                    o_res
);

    localparam int unsigned PROD_W = 2 * ELEM_WIDTH;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  w_prod_ext;
    logic signed [SUM_W-1:0]  n_acc;
    logic signed [SUM_W-1:0]  r_acc;
    t_step                    r_pstep;

    assign n_prod = $signed(i_a) * $signed(i_b);

    // Register the product and its step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstep <= '0;
        end else if (i_adv) begin
            r_pstep <= i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
        end
    end

    // Fit the product to the sum width: sign-extend a narrower one, wrap a wider one modulo 2^35
    generate
        if (PROD_W >= SUM_W) begin : g_trunc
            assign w_prod_ext = r_prod[SUM_W-1:0];
        end else begin : g_sext
            assign w_prod_ext = {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    endgenerate

    // Accumulate, restart on the first term
    assign n_acc = r_pstep.first ? w_prod_ext : r_acc + w_prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_adv && r_pstep.valid) begin
            r_acc <= n_acc;
        end
    end

    // Present the finished sum on the final term
    always_comb begin
        o_res.valid = r_pstep.valid && r_pstep.last_k;
        o_res.row   = r_pstep.row;
        o_res.col   = r_pstep.col;
        o_res.value = r_pstep.err ? '0 : n_acc;
        o_res.last  = r_pstep.last;
        o_res.err   = r_pstep.err;
    end

endmodule
`default_nettype wire

// ----- rtl/mmu_checker.sv -----
// Port-level checker for the matrix multiply unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mmu_checker
    import mmu_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 pready,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic [FUNC_W-1:0]    i_func,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [POS_W-1:0]     o_out_row,
    input wire logic [POS_W-1:0]     o_out_col,
    input wire logic signed [SUM_W-1:0] o_product_value,
    input wire logic                 o_last,
    input wire logic                 o_dim_error
);

    // A mismatch beat is a lone, all-zero final beat
    `MMU_ASSERT_NOW(a_err_beat, i_clk, i_rst_n, o_out_valid && o_dim_error, o_last && (o_out_row == '0) && (o_out_col == '0) && (o_product_value == '0))

    // A compute item blocks further items while it runs
    `MMU_ASSERT_NEXT(a_compute_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_func == FUNC_COMPUTE), o_in_stall)

    // Loads never block the following item
    `MMU_ASSERT_NEXT(a_load_free, i_clk, i_rst_n, i_in_valid && !o_in_stall && ((i_func == FUNC_WRITE_A) || (i_func == FUNC_WRITE_B)), !o_in_stall)

    // A stalled result beat holds
    `MMU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_product_value) && $stable(o_last))

    // Configuration access never waits
    `MMU_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .pready          (pready),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_func          (i_func),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_row       (o_out_row),
    .o_out_col       (o_out_col),
    .o_product_value (o_product_value),
    .o_last          (o_last),
    .o_dim_error     (o_dim_error)
);
`default_nettype wire
